// ----- src/kcl_pkg.sv -----
// Shared types and constants for the keypad code lock.
package kcl_pkg;

   typedef enum logic [2:0] {
      PH_LEN  = 3'd0,
      PH_SET  = 3'd1,
      PH_REP  = 3'd2,
      PH_IDLE = 3'd3,
      PH_VER  = 3'd4,
      PH_NEW  = 3'd5,
      PH_LOCK = 3'd6
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE       = 4'd0,
      EV_KEY        = 4'd1,
      EV_SETUP_DONE = 4'd2,
      EV_MISMATCH   = 4'd3,
      EV_LEN_REJECT = 4'd4,
      EV_WRONG      = 4'd5,
      EV_OPEN       = 4'd6,
      EV_LOCK_START = 4'd7,
      EV_LOCK_END   = 4'd8,
      EV_CHANGED    = 4'd9
   } event_type;

   // control register indexes
   localparam logic [1:0] CSR_MAX_WRONG = 2'd0;
   localparam logic [1:0] CSR_LOCK_TICKS = 2'd1;

   localparam logic       OP_KEY  = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [7:0] KEY_STAR = 8'd42;
   localparam logic [7:0] KEY_HASH = 8'd35;

   localparam logic [7:0] LEN_MIN = 8'd4;
   localparam logic [7:0] LEN_MAX = 8'd6;
   localparam logic [2:0] LEN_RESET = 3'd4;

   localparam logic [3:0] FAIL_SAT = 4'd15;
   localparam logic [3:0] MAX_WRONG_RESET = 4'd3;
   localparam logic [7:0] LOCK_TICKS_RESET = 8'd10;

   // write strobes into the code store
   typedef struct packed {
      logic stage_we;
      logic store_we;
      logic copy_all;
   } store_ctl_type;

endpackage

// ----- src/kcl_code_store.sv -----
// Staged and stored code digit registers with indexed read and write.
module kcl_code_store #(
   parameter int MAX_DIGITS = 6
) (
   input  logic                          clock,
   input  kcl_pkg::store_ctl_type        ctl,
   input  logic [$clog2(MAX_DIGITS)-1:0] idx,
   input  logic [7:0]                    wdata,
   output logic [7:0]                    staged_rd,
   output logic [7:0]                    stored_rd
);

   logic [7:0] staged_ff [MAX_DIGITS];
   logic [7:0] stored_ff [MAX_DIGITS];

   always_ff @(posedge clock) begin
      if (ctl.stage_we) begin
         staged_ff[idx] <= wdata;
      end
      if (ctl.copy_all) begin
         stored_ff <= staged_ff;
      end else if (ctl.store_we) begin
         stored_ff[idx] <= wdata;
      end
   end

   assign staged_rd = staged_ff[idx];
   assign stored_rd = stored_ff[idx];

endmodule

// ----- src/keypad_code_lock.sv -----
// Top level of the keypad code lock controller.
// A request is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the result channel stalls; the whole update is one pass
//   of phase logic and one digit compare between the input register and the result register.
// Reset (synchronous): set-length phase, code length 4, counters cleared, limits 3 and 10.
// Code digits are not reset; setup writes every digit before it is compared.
module keypad_code_lock #(
   parameter int MAX_DIGITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_key_code,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_res,
   output logic [2:0] rsp_phase,
   output logic [3:0] rsp_wrong_attempts,
   output logic [7:0] rsp_lockout_remaining,
   // control register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int PW    = $clog2(MAX_DIGITS);
   localparam int CMP_W = PW + 4;

   // ---- control registers ----
   logic [3:0] max_wrong_ff;
   logic [7:0] lock_ticks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wrong_ff  <= kcl_pkg::MAX_WRONG_RESET;
         lock_ticks_ff <= kcl_pkg::LOCK_TICKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == kcl_pkg::CSR_MAX_WRONG) begin
            max_wrong_ff <= csr_wdata[3:0];
         end else if (csr_index == kcl_pkg::CSR_LOCK_TICKS) begin
            lock_ticks_ff <= csr_wdata;
         end
      end
   end

   // ---- input register ----
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_key_ff;
   logic       rsp_valid_ff;
   logic       fire;

   // the item in the input register is processed once the result register can take it
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_op;
         in_key_ff <= req_key_code;
      end
   end

   // ---- lock state ----
   kcl_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         code_len_ff, code_len_in;
   logic [PW-1:0]      digit_pos_ff, digit_pos_in;
   logic [3:0]         fail_ff, fail_in;
   logic               open_req_ff, open_req_in;
   logic [7:0]         lock_cnt_ff, lock_cnt_in;
   kcl_pkg::event_type ev_in;
   kcl_pkg::store_ctl_type store_ctl;

   logic [7:0]    staged_rd;
   logic [7:0]    stored_rd;
   logic          last_digit;
   logic [PW-1:0] pos_next;
   logic          len_ok;
   logic [3:0]    fail_inc;
   logic          is_tick;
   logic          lock_done;

   kcl_code_store #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_store (
      .clock    (clock),
      .ctl      (store_ctl),
      .idx      (digit_pos_ff),
      .wdata    (in_key_ff),
      .staged_rd(staged_rd),
      .stored_rd(stored_rd)
   );

   // digit position never reaches the code length, so it always indexes a real digit
   assign last_digit = (CMP_W'(digit_pos_ff) + CMP_W'(1)) >= CMP_W'(code_len_ff);
   assign pos_next   = digit_pos_ff + PW'(1);
   assign len_ok     = (in_key_ff >= kcl_pkg::LEN_MIN) && (in_key_ff <= kcl_pkg::LEN_MAX)
                       && (32'(in_key_ff) <= MAX_DIGITS);
   assign fail_inc   = (fail_ff == kcl_pkg::FAIL_SAT) ? fail_ff : fail_ff + 4'd1;
   assign is_tick    = (in_op_ff == kcl_pkg::OP_TICK);
   assign lock_done  = (lock_cnt_ff <= 8'd1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_tick) begin
         if (phase_ff == kcl_pkg::PH_LOCK && lock_done) begin
            phase_in = kcl_pkg::PH_IDLE;
         end
      end else begin
         unique case (phase_ff)
            kcl_pkg::PH_LEN: begin
               if (len_ok) phase_in = kcl_pkg::PH_SET;
            end
            kcl_pkg::PH_SET: begin
               if (last_digit) phase_in = kcl_pkg::PH_REP;
            end
            kcl_pkg::PH_REP: begin
               if (in_key_ff != staged_rd) phase_in = kcl_pkg::PH_LEN;
               else if (last_digit) phase_in = kcl_pkg::PH_IDLE;
            end
            kcl_pkg::PH_IDLE: begin
               if (in_key_ff == kcl_pkg::KEY_HASH || in_key_ff == kcl_pkg::KEY_STAR) begin
                  phase_in = kcl_pkg::PH_VER;
               end
            end
            kcl_pkg::PH_VER: begin
               if (in_key_ff != stored_rd) begin
                  if (fail_inc >= max_wrong_ff) phase_in = kcl_pkg::PH_LOCK;
               end else if (last_digit) begin
                  phase_in = open_req_ff ? kcl_pkg::PH_IDLE : kcl_pkg::PH_NEW;
               end
            end
            kcl_pkg::PH_NEW: begin
               if (last_digit) phase_in = kcl_pkg::PH_IDLE;
            end
            kcl_pkg::PH_LOCK: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // event code, counters and digit store strobes
   always_comb begin
      ev_in        = kcl_pkg::EV_NONE;
      code_len_in  = code_len_ff;
      digit_pos_in = digit_pos_ff;
      fail_in      = fail_ff;
      open_req_in  = open_req_ff;
      lock_cnt_in  = lock_cnt_ff;
      store_ctl    = '0;
      if (is_tick) begin
         if (phase_ff == kcl_pkg::PH_LOCK) begin
            if (lock_done) begin
               lock_cnt_in  = 8'd0;
               fail_in      = 4'd0;
               digit_pos_in = '0;
               ev_in        = kcl_pkg::EV_LOCK_END;
            end else begin
               lock_cnt_in = lock_cnt_ff - 8'd1;
            end
         end
      end else begin
         unique case (phase_ff)
            kcl_pkg::PH_LEN: begin
               if (len_ok) begin
                  code_len_in  = in_key_ff[2:0];
                  digit_pos_in = '0;
                  ev_in        = kcl_pkg::EV_KEY;
               end else begin
                  ev_in = kcl_pkg::EV_LEN_REJECT;
               end
            end
            kcl_pkg::PH_SET: begin
               store_ctl.stage_we = fire;
               digit_pos_in       = last_digit ? '0 : pos_next;
               ev_in              = kcl_pkg::EV_KEY;
            end
            kcl_pkg::PH_REP: begin
               if (in_key_ff != staged_rd) begin
                  digit_pos_in = '0;
                  ev_in        = kcl_pkg::EV_MISMATCH;
               end else if (last_digit) begin
                  store_ctl.copy_all = fire;
                  digit_pos_in       = '0;
                  ev_in              = kcl_pkg::EV_SETUP_DONE;
               end else begin
                  digit_pos_in = pos_next;
                  ev_in        = kcl_pkg::EV_KEY;
               end
            end
            kcl_pkg::PH_IDLE: begin
               if (in_key_ff == kcl_pkg::KEY_HASH || in_key_ff == kcl_pkg::KEY_STAR) begin
                  open_req_in  = (in_key_ff == kcl_pkg::KEY_HASH);
                  fail_in      = 4'd0;
                  digit_pos_in = '0;
                  ev_in        = kcl_pkg::EV_KEY;
               end
            end
            kcl_pkg::PH_VER: begin
               if (in_key_ff != stored_rd) begin
                  digit_pos_in = '0;
                  fail_in      = fail_inc;
                  if (fail_inc >= max_wrong_ff) begin
                     lock_cnt_in = lock_ticks_ff;
                     ev_in       = kcl_pkg::EV_LOCK_START;
                  end else begin
                     ev_in = kcl_pkg::EV_WRONG;
                  end
               end else if (last_digit) begin
                  fail_in      = 4'd0;
                  digit_pos_in = '0;
                  ev_in        = open_req_ff ? kcl_pkg::EV_OPEN : kcl_pkg::EV_KEY;
               end else begin
                  digit_pos_in = pos_next;
                  ev_in        = kcl_pkg::EV_KEY;
               end
            end
            kcl_pkg::PH_NEW: begin
               // code change writes straight into the stored code, no repeat
               store_ctl.store_we = fire;
               digit_pos_in       = last_digit ? '0 : pos_next;
               ev_in              = last_digit ? kcl_pkg::EV_CHANGED : kcl_pkg::EV_KEY;
            end
            kcl_pkg::PH_LOCK: begin
               ev_in = kcl_pkg::EV_NONE;
            end
            default: begin
               ev_in = kcl_pkg::EV_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= kcl_pkg::PH_LEN;
         code_len_ff  <= kcl_pkg::LEN_RESET;
         digit_pos_ff <= '0;
         fail_ff      <= 4'd0;
         open_req_ff  <= 1'b0;
         lock_cnt_ff  <= 8'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         code_len_ff  <= code_len_in;
         digit_pos_ff <= digit_pos_in;
         fail_ff      <= fail_in;
         open_req_ff  <= open_req_in;
         lock_cnt_ff  <= lock_cnt_in;
      end
   end

   // ---- result register ----
   logic [3:0] rsp_event_ff;
   logic [2:0] rsp_phase_ff;
   logic [3:0] rsp_fail_ff;
   logic [7:0] rsp_lock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_event_ff <= ev_in;
         rsp_phase_ff <= phase_in;
         rsp_fail_ff  <= fail_in;
         rsp_lock_ff  <= (phase_in == kcl_pkg::PH_LOCK) ? lock_cnt_in : 8'd0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_res         = rsp_event_ff;
   assign rsp_phase             = rsp_phase_ff;
   assign rsp_wrong_attempts    = rsp_fail_ff;
   assign rsp_lockout_remaining = rsp_lock_ff;

`ifndef ASSERT_OFF
   a_pos_in_code: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(digit_pos_ff) < CMP_W'(code_len_ff))
      else $error("digit position reached code length");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (code_len_ff >= 3'd4) && (code_len_ff <= 3'd6))
      else $error("code length out of range");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed item produced no result");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_key_ff) && $stable(in_op_ff)))
      else $error("pending item lost from input register");

   a_lock_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_phase_ff != kcl_pkg::PH_LOCK) |-> (rsp_lock_ff == 8'd0))
      else $error("lockout count shown outside lockout");
`endif

endmodule
